### src/pft_pkg.sv
// Shared types, step program and fixed-point helpers for the pose frame transform.
`default_nettype none
package pft_pkg;

	localparam int DEVICE_COUNT_DEF = 64;
	localparam int IN_DATA_W  = 240;
	localparam int OUT_DATA_W = 208;
	localparam int OPA_W  = 34;
	localparam int OPB_W  = 24;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = 60;
	localparam int NSTEP  = 52;
	localparam int STEP_W = $clog2(NSTEP + 2);

	localparam logic REQ_POSE  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// control bits of a write request
	localparam int CTL_EN  = 0;
	localparam int CTL_TR  = 1;
	localparam int CTL_ROT = 2;
	localparam int CTL_SCL = 3;

	typedef enum logic [3:0] {
		A_SW, A_SX, A_SY, A_SZ, A_SCL,
		A_M0, A_M1, A_M2, A_M3, A_M4, A_M5, A_M6, A_M7, A_M8
	} a_sel_t;

	typedef enum logic [3:0] {
		B_SW, B_SX, B_SY, B_SZ,
		B_FW, B_FX, B_FY, B_FZ,
		B_P0, B_P1, B_P2,
		B_H0, B_H1, B_H2
	} b_sel_t;

	typedef enum logic [1:0] {BS_ZERO, BS_T0, BS_T1, BS_T2} base_sel_t;

	typedef enum logic [4:0] {
		D_NONE,
		D_M0, D_M1, D_M2, D_M3, D_M4, D_M5, D_M6, D_M7, D_M8,
		D_R0, D_R1, D_R2, D_R3,
		D_P0, D_P1, D_P2,
		D_T0, D_T1, D_T2
	} dst_t;

	typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_RUN, ST_DONE} st_t;

	typedef struct packed {
		a_sel_t    a;
		b_sel_t    b;
		logic      neg;
		logic      first;
		base_sel_t bs;
		dst_t      dst;
	} step_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic neg;
		dst_t dst;
	} mac_ctl_t;

	function automatic step_t mk(input a_sel_t a, input b_sel_t b, input logic neg,
		input logic first, input base_sel_t bs, input dst_t dst);
		step_t s;
		s.a = a; s.b = b; s.neg = neg; s.first = first; s.bs = bs; s.dst = dst;
		return s;
	endfunction

	// Rotation matrix M (off-diagonal entries doubled on store), then the
	// Hamilton product, the scaled position, then M times the frame shift plus translation.
	function automatic step_t step_rom(input logic [STEP_W-1:0] i);
		step_t s;
		s = mk(A_SW, B_SW, 1'b0, 1'b0, BS_ZERO, D_NONE);
		case (i)
			0:  s = mk(A_SW, B_SW, 1'b0, 1'b1, BS_ZERO, D_NONE);
			1:  s = mk(A_SX, B_SX, 1'b0, 1'b0, BS_ZERO, D_NONE);
			2:  s = mk(A_SY, B_SY, 1'b1, 1'b0, BS_ZERO, D_NONE);
			3:  s = mk(A_SZ, B_SZ, 1'b1, 1'b0, BS_ZERO, D_M0);
			4:  s = mk(A_SW, B_SW, 1'b0, 1'b1, BS_ZERO, D_NONE);
			5:  s = mk(A_SX, B_SX, 1'b1, 1'b0, BS_ZERO, D_NONE);
			6:  s = mk(A_SY, B_SY, 1'b0, 1'b0, BS_ZERO, D_NONE);
			7:  s = mk(A_SZ, B_SZ, 1'b1, 1'b0, BS_ZERO, D_M4);
			8:  s = mk(A_SW, B_SW, 1'b0, 1'b1, BS_ZERO, D_NONE);
			9:  s = mk(A_SX, B_SX, 1'b1, 1'b0, BS_ZERO, D_NONE);
			10: s = mk(A_SY, B_SY, 1'b1, 1'b0, BS_ZERO, D_NONE);
			11: s = mk(A_SZ, B_SZ, 1'b0, 1'b0, BS_ZERO, D_M8);
			12: s = mk(A_SX, B_SY, 1'b0, 1'b1, BS_ZERO, D_NONE);
			13: s = mk(A_SW, B_SZ, 1'b1, 1'b0, BS_ZERO, D_M1);
			14: s = mk(A_SX, B_SZ, 1'b0, 1'b1, BS_ZERO, D_NONE);
			15: s = mk(A_SW, B_SY, 1'b0, 1'b0, BS_ZERO, D_M2);
			16: s = mk(A_SX, B_SY, 1'b0, 1'b1, BS_ZERO, D_NONE);
			17: s = mk(A_SW, B_SZ, 1'b0, 1'b0, BS_ZERO, D_M3);
			18: s = mk(A_SY, B_SZ, 1'b0, 1'b1, BS_ZERO, D_NONE);
			19: s = mk(A_SW, B_SX, 1'b1, 1'b0, BS_ZERO, D_M5);
			20: s = mk(A_SX, B_SZ, 1'b0, 1'b1, BS_ZERO, D_NONE);
			21: s = mk(A_SW, B_SY, 1'b1, 1'b0, BS_ZERO, D_M6);
			22: s = mk(A_SY, B_SZ, 1'b0, 1'b1, BS_ZERO, D_NONE);
			23: s = mk(A_SW, B_SX, 1'b0, 1'b0, BS_ZERO, D_M7);
			24: s = mk(A_SW, B_FW, 1'b0, 1'b1, BS_ZERO, D_NONE);
			25: s = mk(A_SX, B_FX, 1'b1, 1'b0, BS_ZERO, D_NONE);
			26: s = mk(A_SY, B_FY, 1'b1, 1'b0, BS_ZERO, D_NONE);
			27: s = mk(A_SZ, B_FZ, 1'b1, 1'b0, BS_ZERO, D_R0);
			28: s = mk(A_SW, B_FX, 1'b0, 1'b1, BS_ZERO, D_NONE);
			29: s = mk(A_SX, B_FW, 1'b0, 1'b0, BS_ZERO, D_NONE);
			30: s = mk(A_SY, B_FZ, 1'b0, 1'b0, BS_ZERO, D_NONE);
			31: s = mk(A_SZ, B_FY, 1'b1, 1'b0, BS_ZERO, D_R1);
			32: s = mk(A_SW, B_FY, 1'b0, 1'b1, BS_ZERO, D_NONE);
			33: s = mk(A_SY, B_FW, 1'b0, 1'b0, BS_ZERO, D_NONE);
			34: s = mk(A_SZ, B_FX, 1'b0, 1'b0, BS_ZERO, D_NONE);
			35: s = mk(A_SX, B_FZ, 1'b1, 1'b0, BS_ZERO, D_R2);
			36: s = mk(A_SW, B_FZ, 1'b0, 1'b1, BS_ZERO, D_NONE);
			37: s = mk(A_SZ, B_FW, 1'b0, 1'b0, BS_ZERO, D_NONE);
			38: s = mk(A_SX, B_FY, 1'b0, 1'b0, BS_ZERO, D_NONE);
			39: s = mk(A_SY, B_FX, 1'b1, 1'b0, BS_ZERO, D_R3);
			40: s = mk(A_SCL, B_P0, 1'b0, 1'b1, BS_ZERO, D_P0);
			41: s = mk(A_SCL, B_P1, 1'b0, 1'b1, BS_ZERO, D_P1);
			42: s = mk(A_SCL, B_P2, 1'b0, 1'b1, BS_ZERO, D_P2);
			43: s = mk(A_M0, B_H0, 1'b0, 1'b1, BS_T0, D_NONE);
			44: s = mk(A_M1, B_H1, 1'b0, 1'b0, BS_ZERO, D_NONE);
			45: s = mk(A_M2, B_H2, 1'b0, 1'b0, BS_ZERO, D_T0);
			46: s = mk(A_M3, B_H0, 1'b0, 1'b1, BS_T1, D_NONE);
			47: s = mk(A_M4, B_H1, 1'b0, 1'b0, BS_ZERO, D_NONE);
			48: s = mk(A_M5, B_H2, 1'b0, 1'b0, BS_ZERO, D_T1);
			49: s = mk(A_M6, B_H0, 1'b0, 1'b1, BS_T2, D_NONE);
			50: s = mk(A_M7, B_H1, 1'b0, 1'b0, BS_ZERO, D_NONE);
			51: s = mk(A_M8, B_H2, 1'b0, 1'b0, BS_ZERO, D_T2);
			default: s = mk(A_SW, B_SW, 1'b0, 1'b0, BS_ZERO, D_NONE);
		endcase
		return s;
	endfunction

	// Round half up at bit sh, then clamp to a w-bit signed range.
	function automatic logic [23:0] rnd_sat(input logic signed [ACC_W-1:0] v,
		input int unsigned sh, input int unsigned w);
		logic signed [ACC_W-1:0] one;
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic [23:0] r;
		one = ACC_W'(1);
		t = v + (one <<< (sh - 1));
		t = t >>> sh;
		hi = (one <<< (w - 1)) - one;
		lo = -hi - one;
		if (t > hi) r = hi[23:0];
		else if (t < lo) r = lo[23:0];
		else r = t[23:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### src/pft_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulator.
`default_nettype none
module pft_mac
	import pft_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mac_ctl_t                ctl,
	input  wire logic signed [OPA_W-1:0] a,
	input  wire logic signed [OPB_W-1:0] b,
	input  wire logic signed [ACC_W-1:0] base,
	output mac_ctl_t                     res_ctl,
	output logic signed [ACC_W-1:0]      acc
);

	mac_ctl_t                   ctl_s1, ctl_s2;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    base_s1, acc_q, term, acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		base_s1 <= base;
		if (ctl_s1.vld) acc_q <= acc_nxt;
	end

	always_comb begin
		term    = ctl_s1.neg ? -ACC_W'(prod_s1) : ACC_W'(prod_s1);
		acc_nxt = (ctl_s1.first ? base_s1 : acc_q) + term;
	end

	assign res_ctl = ctl_s2;
	assign acc     = acc_q;

endmodule
`default_nettype wire

### src/pose_frame_transform_core.sv
// Top level of the pose frame transform: device table, sequencer and output register.
//
// Input stream s_*: one word per request. s_tuser is the request kind (0 pose,
// 1 table write); s_tdata carries device id, control, rotation, scale, position
// and frame shift. A table write lands at its accept edge and gives no result.
// A pose request reads the device entry; a disabled or out-of-range device is
// passed through with applied 0, going from the lookup state straight to the
// finish state, which loads the output register. An enabled device runs 52
// products through one shared 34x24 multiplier, one product per cycle, and
// the last sum passes the product and accumulator registers before the
// finish state. s_tready is high only while the sequencer is idle, so a new
// request is taken only after the last result has gone to the output register.
// Output stream m_*: the result sits in its own register; a stalled receiver
// holds it while the next request is accepted and computed, and only the
// final load waits for the register to drain.
// Reset clears the enable flags and the per-field valid bits of the table, so
// every entry reads as zero until written; the table memory itself is not swept.
`default_nettype none
module pose_frame_transform_core
	import pft_pkg::*;
#(
	parameter int DEVICE_COUNT = DEVICE_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// device_id, control, rotation_packed, scale, pos_x, pos_y, pos_z,
	// shift_x, shift_y, shift_z, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out_rot_w, out_rot_x, out_rot_y, out_rot_z, out_pos_x, out_pos_y,
	// out_pos_z, out_shift_x, out_shift_y, out_shift_z
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// applied
	output logic                       m_tuser
);

	localparam int AW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

	// unpack the input word
	logic [5:0]  in_dev;
	logic [3:0]  in_ctl;
	logic [63:0] in_rot;
	logic [15:0] in_scl;
	logic [71:0] in_pos, in_sh;
	logic [8:0]  dev_ext;
	logic [AW-1:0] addr;
	logic        hit, acc_in, wr_acc, pose_acc;

	assign in_dev  = s_tdata[5:0];
	assign in_ctl  = s_tdata[9:6];
	assign in_rot  = s_tdata[73:10];
	assign in_scl  = s_tdata[89:74];
	assign in_pos  = s_tdata[161:90];
	assign in_sh   = s_tdata[233:162];
	assign dev_ext = {3'b000, in_dev};
	assign addr    = dev_ext[AW-1:0];
	assign hit     = 32'(in_dev) < DEVICE_COUNT;
	assign acc_in  = s_tvalid && s_tready;
	assign wr_acc  = acc_in && (s_tuser == REQ_WRITE) && hit;
	assign pose_acc = acc_in && (s_tuser == REQ_POSE);

	// device table: memories plus per-field valid bits
	logic [63:0] rot_mem [DEVICE_COUNT];
	logic [71:0] tr_mem  [DEVICE_COUNT];
	logic [15:0] sc_mem  [DEVICE_COUNT];
	logic [DEVICE_COUNT-1:0] en_q, rot_vld_q, tr_vld_q, sc_vld_q;

	always_ff @(posedge clk) begin
		if (wr_acc && in_ctl[CTL_ROT]) rot_mem[addr] <= in_rot;
		if (wr_acc && in_ctl[CTL_TR])  tr_mem[addr]  <= in_sh;
		if (wr_acc && in_ctl[CTL_SCL]) sc_mem[addr]  <= in_scl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= '0;
			rot_vld_q <= '0;
			tr_vld_q  <= '0;
			sc_vld_q  <= '0;
		end else if (wr_acc) begin
			en_q[addr] <= in_ctl[CTL_EN];
			if (in_ctl[CTL_ROT]) rot_vld_q[addr] <= 1'b1;
			if (in_ctl[CTL_TR])  tr_vld_q[addr]  <= 1'b1;
			if (in_ctl[CTL_SCL]) sc_vld_q[addr]  <= 1'b1;
		end
	end

	// latch the pose request and read its entry
	logic [63:0] fq_q, rot_rd_q;
	logic [71:0] pos_q, sh_q, tr_rd_q;
	logic [15:0] sc_rd_q;
	logic        hit_q, en_rd_q, rot_v_q, tr_v_q, sc_v_q;

	always_ff @(posedge clk) begin
		if (pose_acc) begin
			fq_q     <= in_rot;
			pos_q    <= in_pos;
			sh_q     <= in_sh;
			hit_q    <= hit;
			en_rd_q  <= hit && en_q[addr];
			rot_v_q  <= hit && rot_vld_q[addr];
			tr_v_q   <= hit && tr_vld_q[addr];
			sc_v_q   <= hit && sc_vld_q[addr];
			rot_rd_q <= rot_mem[addr];
			tr_rd_q  <= tr_mem[addr];
			sc_rd_q  <= sc_mem[addr];
		end
	end

	// never-written fields read as zero
	logic [63:0] srot;
	logic [71:0] stra;
	logic [15:0] sscl;
	logic        app;
	logic signed [15:0] sq [4];
	logic signed [15:0] fq [4];
	logic signed [23:0] pv [3];
	logic signed [23:0] hv [3];
	logic signed [23:0] tv [3];

	assign srot = rot_v_q ? rot_rd_q : '0;
	assign stra = tr_v_q ? tr_rd_q : '0;
	assign sscl = sc_v_q ? sc_rd_q : '0;
	assign app  = hit_q && en_rd_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sq[i] = srot[16*i +: 16];
			fq[i] = fq_q[16*i +: 16];
		end
		for (int i = 0; i < 3; i++) begin
			pv[i] = pos_q[24*i +: 24];
			hv[i] = sh_q[24*i +: 24];
			tv[i] = stra[24*i +: 24];
		end
	end

	// sequencer
	st_t st_q, st_d;
	logic [STEP_W-1:0] step_q;
	logic issue, load_out;
	step_t step;

	assign step = step_rom(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			step_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_LOOK) step_q <= '0;
			else if (st_q == ST_RUN) step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		st_d     = st_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser == REQ_POSE) st_d = ST_LOOK;
			end
			ST_LOOK: st_d = app ? ST_RUN : ST_DONE;
			ST_RUN: begin
				issue = 32'(step_q) < NSTEP;
				// the last product must pass the product and accumulator registers before write-back
				if (32'(step_q) == NSTEP + 1) st_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					load_out = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// operand selection for the shared multiplier
	logic signed [33:0] m_q [9];
	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic signed [ACC_W-1:0] base, acc;
	mac_ctl_t ctl, res_ctl;

	always_comb begin
		unique case (step.a)
			A_SW:  opa = OPA_W'(sq[0]);
			A_SX:  opa = OPA_W'(sq[1]);
			A_SY:  opa = OPA_W'(sq[2]);
			A_SZ:  opa = OPA_W'(sq[3]);
			A_SCL: opa = OPA_W'(sscl);
			A_M0:  opa = m_q[0];
			A_M1:  opa = m_q[1];
			A_M2:  opa = m_q[2];
			A_M3:  opa = m_q[3];
			A_M4:  opa = m_q[4];
			A_M5:  opa = m_q[5];
			A_M6:  opa = m_q[6];
			A_M7:  opa = m_q[7];
			A_M8:  opa = m_q[8];
			default: opa = '0;
		endcase
		unique case (step.b)
			B_SW: opb = OPB_W'(sq[0]);
			B_SX: opb = OPB_W'(sq[1]);
			B_SY: opb = OPB_W'(sq[2]);
			B_SZ: opb = OPB_W'(sq[3]);
			B_FW: opb = OPB_W'(fq[0]);
			B_FX: opb = OPB_W'(fq[1]);
			B_FY: opb = OPB_W'(fq[2]);
			B_FZ: opb = OPB_W'(fq[3]);
			B_P0: opb = pv[0];
			B_P1: opb = pv[1];
			B_P2: opb = pv[2];
			B_H0: opb = hv[0];
			B_H1: opb = hv[1];
			B_H2: opb = hv[2];
			default: opb = '0;
		endcase
		// stored translation enters the sum at the Q.28 point
		unique case (step.bs)
			BS_ZERO: base = '0;
			BS_T0:   base = ACC_W'(tv[0]) <<< 28;
			BS_T1:   base = ACC_W'(tv[1]) <<< 28;
			BS_T2:   base = ACC_W'(tv[2]) <<< 28;
			default: base = '0;
		endcase
		ctl.vld   = issue;
		ctl.first = step.first;
		ctl.neg   = step.neg;
		ctl.dst   = issue ? step.dst : D_NONE;
	end

	pft_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.a       (opa),
		.b       (opb),
		.base    (base),
		.res_ctl (res_ctl),
		.acc     (acc)
	);

	// write back finished sums
	logic [15:0] rot_res_q [4];
	logic [23:0] pos_res_q [3];
	logic [23:0] sh_res_q  [3];
	logic signed [ACC_W-1:0] acc2;

	assign acc2 = acc <<< 1;

	always_ff @(posedge clk) begin
		if (res_ctl.vld) begin
			unique case (res_ctl.dst)
				D_NONE: ;
				D_M0: m_q[0] <= acc[33:0];
				D_M1: m_q[1] <= acc2[33:0];
				D_M2: m_q[2] <= acc2[33:0];
				D_M3: m_q[3] <= acc2[33:0];
				D_M4: m_q[4] <= acc[33:0];
				D_M5: m_q[5] <= acc2[33:0];
				D_M6: m_q[6] <= acc2[33:0];
				D_M7: m_q[7] <= acc2[33:0];
				D_M8: m_q[8] <= acc[33:0];
				D_R0: rot_res_q[0] <= 16'(rnd_sat(acc, 14, 16));
				D_R1: rot_res_q[1] <= 16'(rnd_sat(acc, 14, 16));
				D_R2: rot_res_q[2] <= 16'(rnd_sat(acc, 14, 16));
				D_R3: rot_res_q[3] <= 16'(rnd_sat(acc, 14, 16));
				D_P0: pos_res_q[0] <= rnd_sat(acc, 12, 24);
				D_P1: pos_res_q[1] <= rnd_sat(acc, 12, 24);
				D_P2: pos_res_q[2] <= rnd_sat(acc, 12, 24);
				D_T0: sh_res_q[0]  <= rnd_sat(acc, 28, 24);
				D_T1: sh_res_q[1]  <= rnd_sat(acc, 28, 24);
				D_T2: sh_res_q[2]  <= rnd_sat(acc, 28, 24);
				default: ;
			endcase
		end
	end

	// output register: computed result or the pose passed through
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q, out_vld_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_user_q <= app;
			if (app)
				out_data_q <= {sh_res_q[2], sh_res_q[1], sh_res_q[0],
					pos_res_q[2], pos_res_q[1], pos_res_q[0],
					rot_res_q[3], rot_res_q[2], rot_res_q[1], rot_res_q[0]};
			else
				out_data_q <= {sh_q, pos_q, fq_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (load_out) out_vld_q <= 1'b1;
		else if (m_tready) out_vld_q <= 1'b0;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// a pose request always goes to the entry lookup
	a_pose_look: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_POSE) |=> st_q == ST_LOOK)
		else $error("pose request did not start a lookup");

	// a table write never starts the sequencer
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == REQ_WRITE) |=> st_q == ST_IDLE)
		else $error("table write left idle");

	// accumulator results land only while the program runs
	a_wb_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ctl.vld && res_ctl.dst != D_NONE) |-> st_q == ST_RUN)
		else $error("write-back outside run");

	// a new result appears only from the finish state
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q == ST_DONE))
		else $error("result loaded outside finish");

endmodule
`default_nettype wire

### tb/tb_pose_frame_transform_core.sv
// Self-checking testbench for the pose frame transform core: directed and random requests.
`default_nettype none
module tb_pose_frame_transform_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pft_pkg::*;

	typedef struct {
		logic        kind;
		logic [5:0]  dev;
		logic [3:0]  ctl;
		logic [63:0] rot;
		logic [15:0] scl;
		logic signed [23:0] pos [3];
		logic signed [23:0] sh [3];
	} req_t;

	typedef struct {
		logic [15:0] rot [4];
		logic [23:0] pos [3];
		logic [23:0] sh [3];
		logic        applied;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	pose_frame_transform_core uut (.*);

	always #5 clk = ~clk;

	// shadow copy of the device table
	logic        tbl_en [64];
	logic [63:0] tbl_rot [64];
	logic signed [23:0] tbl_tr [64][3];
	logic [15:0] tbl_scl [64];

	req_t  pending_reqs [$];
	pose_t expected_poses [$];
	int    errors = 0;
	bit    stim_done = 0;
	int    hold_off = 0;

	function automatic logic signed [63:0] rnd_floor(input logic signed [63:0] v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [23:0] clamp(input logic signed [63:0] v, input int w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi[23:0];
		if (v < lo) return lo[23:0];
		return v[23:0];
	endfunction

	function automatic logic signed [63:0] qpart(input logic [63:0] p, input int i);
		return 64'(signed'(p[16*i +: 16]));
	endfunction

	// apply a request to the shadow table; returns 1 with a prediction for a pose
	function automatic bit transform_pose(input req_t r, output pose_t e);
		logic signed [63:0] w, x, y, z, a, b, c, d, k, dt, cx, cy, cz;
		logic signed [63:0] res [4];
		logic signed [63:0] rv [3];
		logic signed [63:0] h [3];
		if (r.kind == REQ_WRITE) begin
			tbl_en[r.dev] = r.ctl[CTL_EN];
			if (r.ctl[CTL_TR]) for (int i = 0; i < 3; i++) tbl_tr[r.dev][i] = r.sh[i];
			if (r.ctl[CTL_ROT]) tbl_rot[r.dev] = r.rot;
			if (r.ctl[CTL_SCL]) tbl_scl[r.dev] = r.scl;
			return 0;
		end
		if (!tbl_en[r.dev]) begin
			for (int i = 0; i < 4; i++) e.rot[i] = r.rot[16*i +: 16];
			for (int i = 0; i < 3; i++) begin
				e.pos[i] = r.pos[i];
				e.sh[i] = r.sh[i];
			end
			e.applied = 1'b0;
			return 1;
		end
		w = qpart(tbl_rot[r.dev], 0); x = qpart(tbl_rot[r.dev], 1);
		y = qpart(tbl_rot[r.dev], 2); z = qpart(tbl_rot[r.dev], 3);
		a = qpart(r.rot, 0); b = qpart(r.rot, 1); c = qpart(r.rot, 2); d = qpart(r.rot, 3);
		res[0] = w*a - x*b - y*c - z*d;
		res[1] = w*b + x*a + y*d - z*c;
		res[2] = w*c + y*a + z*b - x*d;
		res[3] = w*d + z*a + x*c - y*b;
		for (int i = 0; i < 4; i++) e.rot[i] = 16'(clamp(rnd_floor(res[i], 14), 16));
		for (int i = 0; i < 3; i++) begin
			e.pos[i] = clamp(rnd_floor(64'(r.pos[i]) * 64'(tbl_scl[r.dev]), 12), 24);
			h[i] = 64'(r.sh[i]);
		end
		k = w*w - x*x - y*y - z*z;
		dt = x*h[0] + y*h[1] + z*h[2];
		cx = y*h[2] - z*h[1];
		cy = z*h[0] - x*h[2];
		cz = x*h[1] - y*h[0];
		rv[0] = k*h[0] + 2*dt*x + 2*w*cx;
		rv[1] = k*h[1] + 2*dt*y + 2*w*cy;
		rv[2] = k*h[2] + 2*dt*z + 2*w*cz;
		for (int i = 0; i < 3; i++)
			e.sh[i] = clamp(rnd_floor(rv[i] + (64'(tbl_tr[r.dev][i]) <<< 28), 28), 24);
		e.applied = 1'b1;
		return 1;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_req(input req_t r);
		return {6'b0, r.sh[2], r.sh[1], r.sh[0], r.pos[2], r.pos[1], r.pos[0],
			r.scl, r.rot, r.ctl, r.dev};
	endfunction

	function automatic logic signed [23:0] rand_vec();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'(signed'($urandom_range(0, 131072)) - 65536);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_q();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t rand_req(input logic kind, input logic [5:0] dev);
		req_t r;
		r.kind = kind;
		r.dev = dev;
		r.ctl = 4'($urandom);
		r.rot = {rand_q(), rand_q(), rand_q(), rand_q()};
		r.scl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h1000;
		for (int i = 0; i < 3; i++) begin
			r.pos[i] = rand_vec();
			r.sh[i] = rand_vec();
		end
		return r;
	endfunction

	// driver: advance to the next word after each accepted one, with random gaps
	int gap = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pose_t e;
			if (transform_pose(pending_reqs.pop_front(), e)) expected_poses.push_back(e);
		end
		if (!(s_tvalid && !s_tready)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pack_req(pending_reqs[0]);
				s_tuser <= pending_reqs[0].kind;
				gap <= ($urandom_range(0, 3) == 0) ?
					(($urandom_range(0, 9) == 0) ? $urandom_range(10, 150) : $urandom_range(1, 3)) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_poses.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				pose_t e;
				e = expected_poses.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_tdata[16*i +: 16] !== e.rot[i]) begin
						$error("out_rot[%0d] expected %h actual %h", i, e.rot[i], m_tdata[16*i +: 16]);
						errors++;
					end
				for (int i = 0; i < 3; i++) begin
					if (m_tdata[64 + 24*i +: 24] !== e.pos[i]) begin
						$error("out_pos[%0d] expected %h actual %h", i, e.pos[i],
							m_tdata[64 + 24*i +: 24]);
						errors++;
					end
					if (m_tdata[136 + 24*i +: 24] !== e.sh[i]) begin
						$error("out_shift[%0d] expected %h actual %h", i, e.sh[i],
							m_tdata[136 + 24*i +: 24]);
						errors++;
					end
				end
				if (m_tuser !== e.applied) begin
					$error("applied expected %b actual %b", e.applied, m_tuser);
					errors++;
				end
			end
		end
	end

	// receiver stalls, with occasional long hold-offs while the sender keeps offering words
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			if ($urandom_range(0, 40) == 0) hold_off <= $urandom_range(20, 200);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		req_t r;
		int waited;
		for (int i = 0; i < 64; i++) begin
			tbl_en[i] = 0; tbl_rot[i] = '0; tbl_scl[i] = '0;
			for (int j = 0; j < 3; j++) tbl_tr[i][j] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: pass-through on reset table, enabled with zero scale, extremes
		r = rand_req(REQ_POSE, 6'd0);
		pending_reqs.push_back(r);
		r = rand_req(REQ_POSE, 6'd63);
		r.rot = 64'h8000_7FFF_8000_7FFF;
		pending_reqs.push_back(r);
		r = rand_req(REQ_WRITE, 6'd1);
		r.ctl = 4'b0001;
		pending_reqs.push_back(r);
		r = rand_req(REQ_POSE, 6'd1);
		pending_reqs.push_back(r);
		r = rand_req(REQ_WRITE, 6'd2);
		r.ctl = 4'b1111; r.rot = {16'd0, 16'd0, 16'd0, 16'h4000}; r.scl = 16'h1000;
		pending_reqs.push_back(r);
		r = rand_req(REQ_POSE, 6'd2);
		pending_reqs.push_back(r);
		// extreme quaternion and scale to drive saturation
		r = rand_req(REQ_WRITE, 6'd3);
		r.ctl = 4'b1111; r.rot = 64'h8000_8000_8000_8000; r.scl = 16'hFFFF;
		r.sh = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
		pending_reqs.push_back(r);
		r = rand_req(REQ_POSE, 6'd3);
		r.rot = 64'h8000_8000_8000_8000;
		r.pos = '{24'sh7FFFFF, 24'sh800000, 24'sh000001};
		r.sh = '{24'sh800000, 24'sh7FFFFF, 24'sh800000};
		pending_reqs.push_back(r);
		r = rand_req(REQ_WRITE, 6'd63);
		r.ctl = 4'b1111; r.rot = 64'h7FFF_7FFF_7FFF_7FFF;
		pending_reqs.push_back(r);
		r = rand_req(REQ_POSE, 6'd63);
		r.rot = '1;
		pending_reqs.push_back(r);
		r = rand_req(REQ_WRITE, 6'd3);
		r.ctl = 4'b0000;
		pending_reqs.push_back(r);
		r = rand_req(REQ_POSE, 6'd3);
		pending_reqs.push_back(r);

		// random: mostly poses among some writes, mostly on a small set of busy devices
		for (int n = 0; n < 1600; n++) begin
			logic [5:0] d;
			d = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
			r = rand_req(($urandom_range(0, 3) == 0) ? REQ_WRITE : REQ_POSE, d);
			if (r.kind == REQ_WRITE && $urandom_range(0, 2) != 0) r.ctl[CTL_EN] = 1'b1;
			pending_reqs.push_back(r);
			while (pending_reqs.size() > 8) @(posedge clk);
		end

		while (pending_reqs.size() > 0 || s_tvalid) @(posedge clk);
		waited = 0;
		while (expected_poses.size() > 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_poses.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire

### pose_frame_transform_core.f
src/pft_pkg.sv
src/pft_mac.sv
src/pose_frame_transform_core.sv
tb/tb_pose_frame_transform_core.sv
